/* rtl/ple_pkg.sv */
`timescale 1ns / 1ps

package ple_pkg;

  // action codes carried on the request side
  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_MODIFY = 3'd3,
    ACT_READ   = 3'd4,
    ACT_FIND   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_NOKEY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_POST,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic decode;
    logic clear;
    logic start;
    logic walk;
    logic modify;
    logic post;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t act;
    logic    op_ok;
    logic    walk_done;
    logic    res_free;
  } sts_t;

  localparam int POS_BITS   = 7;
  localparam int IN_KEY_BITS = 32;
  localparam int PAY_BITS   = 32;

endpackage

/* rtl/ple_ctrl.sv */
`timescale 1ns / 1ps

module ple_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ple_pkg::sts_t sts,
  output ple_pkg::cmd_t cmd
);

  ple_pkg::state_t state;
  ple_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ple_pkg::S_IDLE: begin
        if (req_valid) state_next = ple_pkg::S_DECODE;
      end
      ple_pkg::S_DECODE: begin
        if (sts.op_ok && (sts.act inside {ple_pkg::ACT_INSERT, ple_pkg::ACT_REMOVE,
                                          ple_pkg::ACT_READ, ple_pkg::ACT_FIND})) begin
          state_next = ple_pkg::S_WALK;
        end else begin
          state_next = ple_pkg::S_FINISH;
        end
      end
      ple_pkg::S_WALK: begin
        if (sts.walk_done) state_next = ple_pkg::S_POST;
      end
      ple_pkg::S_POST: begin
        state_next = ple_pkg::S_FINISH;
      end
      ple_pkg::S_FINISH: begin
        if (sts.res_free) state_next = ple_pkg::S_IDLE;
      end
      default: begin
        state_next = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ple_pkg::S_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      ple_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        cmd.clear  = (sts.act == ple_pkg::ACT_CLEAR);
        cmd.modify = sts.op_ok && (sts.act == ple_pkg::ACT_MODIFY);
        cmd.start  = sts.op_ok && (sts.act inside {ple_pkg::ACT_INSERT, ple_pkg::ACT_REMOVE,
                                                   ple_pkg::ACT_READ, ple_pkg::ACT_FIND});
      end
      ple_pkg::S_WALK: begin
        cmd.walk = 1'b1;
      end
      ple_pkg::S_POST: begin
        cmd.post = 1'b1;
      end
      ple_pkg::S_FINISH: begin
        cmd.load = sts.res_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/ple_dp.sv */
`timescale 1ns / 1ps

module ple_dp #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ple_pkg::cmd_t                 cmd,
  output ple_pkg::sts_t                 sts,
  input  logic [2:0]                    in_action,
  input  logic [ple_pkg::POS_BITS-1:0]  in_position,
  input  logic [ple_pkg::IN_KEY_BITS-1:0] in_key,
  input  logic [ple_pkg::PAY_BITS-1:0]  in_payload,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [1:0]                    res_status,
  output logic [ple_pkg::POS_BITS-1:0]  res_found,
  output logic [ple_pkg::IN_KEY_BITS-1:0] res_key,
  output logic [ple_pkg::PAY_BITS-1:0]  res_payload,
  output logic [ple_pkg::POS_BITS-1:0]  res_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = ((CW > ple_pkg::POS_BITS) ? CW : ple_pkg::POS_BITS) + 1;

  // request registers
  ple_pkg::action_t                 act;
  logic [ple_pkg::POS_BITS-1:0]     pos;
  logic [KEY_BITS-1:0]              key;
  logic [ple_pkg::PAY_BITS-1:0]     pay;

  logic [CW-1:0]                    count;

  // entry store, one write and one registered read a cycle
  logic [KEY_BITS-1:0]              key_mem [CAPACITY];
  logic [ple_pkg::PAY_BITS-1:0]     pay_mem [CAPACITY];
  logic [KEY_BITS-1:0]              rd_key;
  logic [ple_pkg::PAY_BITS-1:0]     rd_pay;

  // walker
  logic [AW-1:0]                    raddr;
  logic [CW-1:0]                    left;
  logic                             pend;
  logic [AW-1:0]                    pidx;

  // collected result
  ple_pkg::status_t                 stat;
  logic                             hit;
  logic [WW-1:0]                    fpos;
  logic [KEY_BITS-1:0]              got_key;
  logic [ple_pkg::PAY_BITS-1:0]     got_pay;

  logic [WW-1:0]                    cnt_w;
  logic [WW-1:0]                    pos_w;
  logic [AW-1:0]                    p0;
  ple_pkg::status_t                 stat_c;
  logic                             we;
  logic [AW-1:0]                    waddr;
  logic [KEY_BITS-1:0]              wkey;
  logic [ple_pkg::PAY_BITS-1:0]     wpay;
  logic [63:0]                      key64;

  assign cnt_w = WW'(count);
  assign pos_w = WW'(pos);
  assign p0    = AW'(pos_w - WW'(1));

  always_comb begin
    stat_c = ple_pkg::ST_OK;
    case (act)
      ple_pkg::ACT_INSERT: begin
        if (count == CW'(CAPACITY)) stat_c = ple_pkg::ST_FULL;
        else if (pos_w == '0 || pos_w > cnt_w + WW'(1)) stat_c = ple_pkg::ST_BADPOS;
      end
      ple_pkg::ACT_REMOVE, ple_pkg::ACT_MODIFY, ple_pkg::ACT_READ: begin
        if (pos_w == '0 || pos_w > cnt_w) stat_c = ple_pkg::ST_BADPOS;
      end
      default: begin
        stat_c = ple_pkg::ST_OK;
      end
    endcase
  end

  assign sts.act       = act;
  assign sts.op_ok     = (stat_c == ple_pkg::ST_OK);
  assign sts.walk_done = (left == '0) && !pend;
  assign sts.res_free  = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act <= ple_pkg::action_t'(in_action);
      pos <= in_position;
      key <= KEY_BITS'(64'(in_key));
      pay <= in_payload;
    end
    if (cmd.decode) stat <= stat_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.post && act == ple_pkg::ACT_INSERT) begin
      count <= count + CW'(1);
    end else if (cmd.post && act == ple_pkg::ACT_REMOVE) begin
      count <= count - CW'(1);
    end
  end

  // walker: insert runs downward from the tail, remove and find run upward, read fetches one entry
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      pend <= 1'b0;
    end else if (cmd.start) begin
      pend <= 1'b0;
      case (act)
        ple_pkg::ACT_INSERT: begin
          raddr <= AW'(cnt_w - WW'(1));
          left  <= CW'(cnt_w - pos_w + WW'(1));
        end
        ple_pkg::ACT_REMOVE: begin
          raddr <= AW'(pos_w);
          left  <= CW'(cnt_w - pos_w);
        end
        ple_pkg::ACT_READ: begin
          raddr <= p0;
          left  <= CW'(1);
        end
        default: begin
          raddr <= '0;
          left  <= count;
        end
      endcase
    end else if (cmd.walk) begin
      pend <= (left != '0);
      if (left != '0) begin
        pidx  <= raddr;
        left  <= left - CW'(1);
        raddr <= (act == ple_pkg::ACT_INSERT) ? raddr - AW'(1) : raddr + AW'(1);
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = p0;
    wkey  = key;
    wpay  = pay;
    if (cmd.walk && pend && act == ple_pkg::ACT_INSERT) begin
      we    = 1'b1;
      waddr = pidx + AW'(1);
      wkey  = rd_key;
      wpay  = rd_pay;
    end else if (cmd.walk && pend && act == ple_pkg::ACT_REMOVE) begin
      we    = 1'b1;
      waddr = pidx - AW'(1);
      wkey  = rd_key;
      wpay  = rd_pay;
    end else if (cmd.modify || (cmd.post && act == ple_pkg::ACT_INSERT)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      pay_mem[waddr] <= wpay;
    end
    rd_key <= key_mem[raddr];
    rd_pay <= pay_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.accept) begin
      hit     <= 1'b0;
      fpos    <= '0;
      got_key <= '0;
      got_pay <= '0;
    end else if (cmd.walk && pend) begin
      if (act == ple_pkg::ACT_READ) begin
        got_key <= rd_key;
        got_pay <= rd_pay;
      end else if (act == ple_pkg::ACT_FIND && !hit && rd_key == key) begin
        hit     <= 1'b1;
        got_key <= rd_key;
        got_pay <= rd_pay;
        fpos    <= WW'(pidx) + WW'(1);
      end
    end
  end

  assign key64 = 64'(got_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (act == ple_pkg::ACT_FIND) begin
        res_status <= hit ? ple_pkg::ST_OK : ple_pkg::ST_NOKEY;
      end else begin
        res_status <= stat;
      end
      res_found   <= fpos[ple_pkg::POS_BITS-1:0];
      res_key     <= key64[ple_pkg::IN_KEY_BITS-1:0];
      res_payload <= got_pay;
      res_count   <= cnt_w[ple_pkg::POS_BITS-1:0];
    end
  end

endmodule

/* rtl/positional_list_engine.sv */
`timescale 1ns / 1ps

// positional list engine: ordered list of up to CAPACITY (key, payload) entries
// request channel s_axis_*: tuser carries the action (clear, insert, remove,
//   modify, read, find), tdata carries position, key and payload
// result channel m_axis_*: tuser carries the status, tdata carries found
//   position, entry read, and the entry count after the action
// exactly one result per request, in request order
// one request is worked at a time; the store is a single-port-write,
//   registered-read memory, so shifting and searching move one entry a cycle
// the next request is taken in the cycle after a result is loaded
// a finished result sits in the output register while the next request is
//   accepted; a stalled receiver only holds the block once a second result
//   is ready to go out
// synchronous reset empties the list (count zero) and drops any pending result;
//   entry contents are left as they were and are never read until rewritten
module positional_list_engine #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // position[6:0], entry_key[38:7], entry_payload[70:39]
  input  logic [2:0]  s_axis_tuser,   // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // found_position[6:0], read_key[38:7],
                                      // read_payload[70:39], entry_count[77:71]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;

  logic [ple_pkg::POS_BITS-1:0] res_found;
  logic [ple_pkg::IN_KEY_BITS-1:0] res_key;
  logic [ple_pkg::PAY_BITS-1:0] res_payload;
  logic [ple_pkg::POS_BITS-1:0] res_count;

  // sequencer: accept, decode, walk, post, finish, hand off result
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store, count, walker and output register
  ple_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (s_axis_tuser),
    .in_position (s_axis_tdata[6:0]),
    .in_key      (s_axis_tdata[38:7]),
    .in_payload  (s_axis_tdata[70:39]),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res_status  (m_axis_tuser),
    .res_found   (res_found),
    .res_key     (res_key),
    .res_payload (res_payload),
    .res_count   (res_count)
  );

  // top two bits are byte fill
  assign m_axis_tdata = {2'b00, res_count, res_payload, res_key, res_found};

endmodule
